[sv/lru_pkg.sv]
//------------------------------------------------------------------------------
// lru_pkg
// Shared types and constants for the LRU page replacement MMU.
//------------------------------------------------------------------------------
package lru_pkg;

   localparam int unsigned REQ_ADDR_W = 32;
   localparam int unsigned CNT_W      = 32;

   typedef enum logic [1:0] {
      CSR_PAGE_OFFSET_BITS = 2'd0,
      CSR_PAGES_IN_USE     = 2'd1,
      CSR_FRAMES_IN_USE    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OUT_HIT     = 2'd0,
      OUT_FREE    = 2'd1,
      OUT_REPLACE = 2'd2,
      OUT_ILLEGAL = 2'd3
   } outcome_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN_OWNER,
      ST_SCAN_STAMP,
      ST_SCAN_DRAIN,
      ST_VICTIM_OWNER,
      ST_VICTIM_WAIT,
      ST_COMMIT,
      ST_FINISH,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic        cmd;
      logic [31:0] virtual_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [31:0] physical_address;
      logic [5:0]  frame_used;
      logic [7:0]  evicted_page;
      logic        writeback_needed;
      logic [31:0] fault_total;
      logic [31:0] illegal_total;
      logic [31:0] read_total;
      logic [31:0] write_total;
      logic [31:0] writeback_total;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;    // latch request and decode
      logic scan_start; // reset scan index and best
      logic owner_rd;   // issue owner read at scan index
      logic stamp_rd;   // issue stamp read for owner data
      logic compare;    // compare stamp against best
      logic scan_next;  // bump scan index
      logic victim_rd;  // read owner of best frame
      logic victim_pg;  // latch victim page
      logic commit;     // apply state updates
      logic finish;     // build response
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic illegal;
      logic present;
      logic has_free;
      logic scan_last;
   } sts_type;

endpackage

[sv/mmu_lru_page_replacement.sv]
//------------------------------------------------------------------------------
// mmu_lru_page_replacement
// Demand-paging MMU with LRU replacement over a frame timestamp scan.
//------------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready carry one access (read or write, virtual address).
//   rsp_valid/rsp_ready return one result per access: outcome, physical
//   address, frame, victim page, writeback flag and running counters.
//   csr_valid/csr_ready write page_offset_bits, pages_in_use, frames_in_use
//   (index 0..2); write only while no transaction is in flight.
// Sequence: a hit, free-frame fault or illegal access passes through lookup,
//   commit and finish before rsp_valid rises. A replacement fault first scans
//   every frame in use with an owner read and then a stamp read, drains the
//   last compare and reads the victim's owner before commit and finish.
// One access is worked at a time; the next is accepted in the cycle the
//   response is taken. A stalled response holds until rsp_ready.
// Reset clears residency, dirty bits, clock, frame count and counters;
//   page tables need no clearing pass.
//------------------------------------------------------------------------------
module mmu_lru_page_replacement
   import lru_pkg::*;
#(
   parameter int unsigned MAX_PAGES  = 256,
   parameter int unsigned MAX_FRAMES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [4:0] offset_bits_ff;
   logic [8:0] pages_ff;
   logic [6:0] frames_ff;
   ctl_type    ctl;
   sts_type    sts;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= 5'd8;
         pages_ff       <= 9'd256;
         frames_ff      <= 7'd64;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PAGE_OFFSET_BITS: offset_bits_ff <= csr_data[4:0];
            CSR_PAGES_IN_USE:     pages_ff       <= csr_data[8:0];
            CSR_FRAMES_IN_USE:    frames_ff      <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   lru_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .ctl
   );

   lru_datapath #(.MAX_PAGES(MAX_PAGES), .MAX_FRAMES(MAX_FRAMES)) u_datapath (
      .clock, .reset,
      .offset_bits(offset_bits_ff), .pages_cfg(pages_ff), .frames_cfg(frames_ff),
      .req(req_payload), .ctl, .sts, .rsp(rsp_payload)
   );

endmodule

[sv/lru_datapath.sv]
//------------------------------------------------------------------------------
// lru_datapath
// Page tables, frame owner memory, victim scan and statistics counters.
//------------------------------------------------------------------------------
module lru_datapath
   import lru_pkg::*;
#(
   parameter int unsigned MAX_PAGES  = 256,
   parameter int unsigned MAX_FRAMES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [4:0]  offset_bits,
   input  logic [8:0]  pages_cfg,
   input  logic [6:0]  frames_cfg,
   input  req_type     req,
   input  ctl_type     ctl,
   output sts_type     sts,
   output rsp_type     rsp
);

   localparam int unsigned PW = (MAX_PAGES  > 1) ? $clog2(MAX_PAGES)  : 1;
   localparam int unsigned FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int unsigned FCW = $clog2(MAX_FRAMES + 1);

   // stores
   logic [MAX_PAGES-1:0] present_ff;
   logic [MAX_PAGES-1:0] dirty_ff;
   logic [FW-1:0]        frame_mem [MAX_PAGES];
   logic [31:0]          stamp_mem [MAX_PAGES];
   logic [PW-1:0]        owner_mem [MAX_FRAMES];

   logic [31:0]  clock_ff;
   logic [FCW-1:0] taken_ff;
   logic [31:0]  fault_ff, illegal_ff, read_ff, write_ff, wb_ff;

   // transaction registers
   logic         is_write_ff;
   logic [31:0]  offset_ff;
   logic [4:0]   sh_ff;
   logic [PW-1:0] page_ff;
   logic         page_illegal_ff, present_q_ff;
   logic [FCW-1:0] limit_ff;
   logic [FW-1:0] pframe_rd_ff;

   // scan registers
   logic [FCW-1:0] idx_ff;
   logic [FW-1:0]  cand_ff, best_ff;
   logic [31:0]    best_stamp_ff;
   logic [PW-1:0]  owner_rd_ff;
   logic [31:0]    stamp_rd_ff;
   logic [PW-1:0]  victim_ff;
   logic [1:0]     outcome_ff;
   logic [FW-1:0]  frame_ff;
   logic           wb_flag_ff;
   logic [PW-1:0]  evict_ff;

   // request decode
   logic [31:0] page_full;
   logic [31:0] page_lim;
   logic [FCW-1:0] frame_lim;
   logic        req_illegal;
   always_comb begin
      page_full = req.virtual_address >> offset_bits;
      page_lim  = (32'(pages_cfg) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES) : 32'(pages_cfg);
      req_illegal = page_full >= page_lim;
      if (frames_cfg == 7'd0)
         frame_lim = FCW'(1);
      else if (32'(frames_cfg) > 32'(MAX_FRAMES))
         frame_lim = FCW'(MAX_FRAMES);
      else
         frame_lim = FCW'(frames_cfg);
   end

   // capture
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         is_write_ff     <= req.cmd;
         sh_ff           <= offset_bits;
         offset_ff       <= req.virtual_address & ((32'd1 << offset_bits) - 32'd1);
         page_ff         <= page_full[PW-1:0];
         page_illegal_ff <= req_illegal;
         present_q_ff    <= present_ff[page_full[PW-1:0]];
         limit_ff        <= frame_lim;
      end
   end

   always_comb begin
      sts.illegal   = page_illegal_ff;
      sts.present   = present_q_ff;
      sts.has_free  = taken_ff < limit_ff;
      sts.scan_last = (idx_ff + FCW'(1)) >= limit_ff;
   end

   // scan of frame timestamps, lowest frame wins a tie
   always_ff @(posedge clock) begin
      if (ctl.scan_start) begin
         idx_ff        <= '0;
         best_ff       <= '0;
         best_stamp_ff <= '1;
      end else if (ctl.scan_next) begin
         idx_ff <= idx_ff + FCW'(1);
      end
      if (ctl.owner_rd || ctl.victim_rd) begin
         owner_rd_ff <= owner_mem[ctl.victim_rd ? best_ff : idx_ff[FW-1:0]];
         cand_ff     <= idx_ff[FW-1:0];
      end
      if (ctl.stamp_rd) stamp_rd_ff <= stamp_mem[owner_rd_ff];
      if (ctl.compare && (cand_ff == '0 || best_stamp_ff > stamp_rd_ff)) begin
         best_ff       <= cand_ff;
         best_stamp_ff <= stamp_rd_ff;
      end
      if (ctl.victim_pg) victim_ff <= owner_rd_ff;
      if (ctl.capture) pframe_rd_ff <= frame_mem[page_full[PW-1:0]];
   end

   // state update
   logic [FW-1:0] new_frame;
   always_comb begin
      new_frame = sts.has_free ? taken_ff[FW-1:0] : best_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.commit && !page_illegal_ff && !present_q_ff) begin
         owner_mem[new_frame] <= page_ff;
         frame_mem[page_ff]   <= new_frame;
      end
      if (ctl.commit && !page_illegal_ff) stamp_mem[page_ff] <= clock_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         dirty_ff   <= '0;
         clock_ff   <= '0;
         taken_ff   <= '0;
         fault_ff   <= '0;
         illegal_ff <= '0;
         read_ff    <= '0;
         write_ff   <= '0;
         wb_ff      <= '0;
      end else if (ctl.commit) begin
         if (page_illegal_ff) begin
            illegal_ff <= illegal_ff + 32'd1;
         end else begin
            clock_ff <= clock_ff + 32'd1;
            if (is_write_ff) write_ff <= write_ff + 32'd1;
            else             read_ff  <= read_ff + 32'd1;
            if (!present_q_ff) begin
               fault_ff <= fault_ff + 32'd1;
               if (sts.has_free) begin
                  taken_ff <= taken_ff + FCW'(1);
               end else begin
                  present_ff[victim_ff] <= 1'b0;
                  if (dirty_ff[victim_ff]) wb_ff <= wb_ff + 32'd1;
               end
               present_ff[page_ff] <= 1'b1;
            end
            dirty_ff[page_ff] <= is_write_ff | (present_q_ff & dirty_ff[page_ff]);
         end
      end
   end

   // result fields latched with the update
   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         evict_ff   <= '0;
         wb_flag_ff <= 1'b0;
         if (page_illegal_ff) begin
            outcome_ff <= OUT_ILLEGAL;
            frame_ff   <= '0;
         end else if (present_q_ff) begin
            outcome_ff <= OUT_HIT;
            frame_ff   <= pframe_rd_ff;
         end else if (sts.has_free) begin
            outcome_ff <= OUT_FREE;
            frame_ff   <= new_frame;
         end else begin
            outcome_ff <= OUT_REPLACE;
            frame_ff   <= new_frame;
            evict_ff   <= victim_ff;
            wb_flag_ff <= dirty_ff[victim_ff];
         end
      end
   end

   // response build
   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp.outcome          <= outcome_ff;
         rsp.physical_address <= (outcome_ff == OUT_ILLEGAL) ? '1 :
                                 ((32'(frame_ff) << sh_ff) | offset_ff);
         rsp.frame_used       <= 6'(frame_ff);
         rsp.evicted_page     <= 8'(evict_ff);
         rsp.writeback_needed <= wb_flag_ff;
         rsp.fault_total      <= fault_ff;
         rsp.illegal_total    <= illegal_ff;
         rsp.read_total       <= read_ff;
         rsp.write_total      <= write_ff;
         rsp.writeback_total  <= wb_ff;
      end
   end

endmodule

[sv/lru_control.sv]
//------------------------------------------------------------------------------
// lru_control
// Sequencer for lookup, victim scan, update and response handshake.
//------------------------------------------------------------------------------
module lru_control
   import lru_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output ctl_type ctl
);

   state_type state_ff, state_in;
   logic      cmp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_LOOKUP;
         ST_LOOKUP: begin
            if (sts.illegal || sts.present || sts.has_free) state_in = ST_COMMIT;
            else state_in = ST_SCAN_OWNER;
         end
         ST_SCAN_OWNER: state_in = ST_SCAN_STAMP;
         ST_SCAN_STAMP: state_in = sts.scan_last ? ST_SCAN_DRAIN : ST_SCAN_OWNER;
         ST_SCAN_DRAIN: state_in = ST_VICTIM_OWNER;
         ST_VICTIM_OWNER: state_in = ST_VICTIM_WAIT;
         ST_VICTIM_WAIT:  state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_FINISH;
         ST_FINISH: state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (rsp_ready) state_in = req_valid ? ST_LOOKUP : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      // compare is asserted in the cycle after the stamp read
      ctl.compare = cmp_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            ctl.capture = req_valid;
         end
         ST_LOOKUP:     ctl.scan_start = 1'b1;
         ST_SCAN_OWNER: ctl.owner_rd = 1'b1;
         ST_SCAN_STAMP: begin
            ctl.stamp_rd  = 1'b1;
            ctl.scan_next = 1'b1;
         end
         ST_VICTIM_OWNER: ctl.victim_rd = 1'b1;
         ST_VICTIM_WAIT:  ctl.victim_pg = 1'b1;
         ST_COMMIT:  ctl.commit = 1'b1;
         ST_FINISH:  ctl.finish = 1'b1;
         ST_RESPOND: begin
            rsp_valid   = 1'b1;
            req_ready   = rsp_ready;
            ctl.capture = rsp_ready & req_valid;
         end
         default: ;
      endcase
   end

   // compare strobe in the cycle after each stamp read
   always_ff @(posedge clock) begin
      if (reset) cmp_ff <= 1'b0;
      else       cmp_ff <= (state_ff == ST_SCAN_STAMP);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

[sv/lru_checker.sv]
//------------------------------------------------------------------------------
// lru_checker
// Port-level checks for the LRU MMU, bound to the top level.
//------------------------------------------------------------------------------
module lru_checker
   import lru_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // response holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // no response in the cycle after acceptance
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("response too early");

   // illegal result carries all ones address and no evicted page
   a_illegal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.outcome == OUT_ILLEGAL |->
      rsp_payload.physical_address == '1 && rsp_payload.evicted_page == '0)
      else $error("illegal result malformed");

   // writeback only on replacement
   a_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.writeback_needed |->
      rsp_payload.outcome == OUT_REPLACE)
      else $error("writeback without replacement");

endmodule

bind mmu_lru_page_replacement lru_checker u_lru_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_payload
);
